FILE: hdl/hee_pkg.sv
// Shared types, constants and run builder for the HTML entity encoder.
`default_nettype none
package hee_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned RUN_MAX     = 6;

   // configuration register indexes
   localparam logic [1:0] CSR_USE_NAMES  = 2'd0;
   localparam logic [1:0] CSR_USE_HEX    = 2'd1;
   localparam logic [1:0] CSR_ENCODE_ALL = 2'd2;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_QUOT  = 8'h22;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_LOW_A = 8'h61;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       out_message_end;
   } rsp_type;

   typedef struct packed {
      logic use_names;
      logic use_hex;
      logic encode_all;
   } cfg_type;

   // one encoded run: bytes, index of its final byte, message end flag
   typedef struct packed {
      logic [RUN_MAX-1:0][7:0] text;
      logic [2:0]              last_idx;
      logic                    msg_end;
   } run_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = CH_ZERO + {4'd0, nib};
      end else begin
         ch = CH_LOW_A + {4'd0, nib} - 8'd10;
      end
      return ch;
   endfunction

   function automatic run_type build_run(input req_type req, input cfg_type cfg);
      run_type    run;
      logic       reserved;
      logic [1:0] hund;
      logic [6:0] rem;
      logic [3:0] tens;
      logic [3:0] ones;
      logic [2:0] idx;
      logic [7:0] b;
      b        = req.data_byte;
      run      = '0;
      run.msg_end = req.message_end;
      reserved = (b == CH_LT) || (b == CH_GT) || (b == CH_AMP) ||
                 (b == CH_APOS) || (b == CH_QUOT);
      // decimal digits by compare and subtract
      if (b >= 8'd200) begin
         hund = 2'd2;
      end else if (b >= 8'd100) begin
         hund = 2'd1;
      end else begin
         hund = 2'd0;
      end
      rem  = 7'(b - 8'd100 * {6'd0, hund});
      tens = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (rem >= 7'(10 * k)) tens = 4'(k);
      end
      ones = 4'(rem - 7'd10 * {3'd0, tens});
      idx  = 3'd2;
      run.text[0] = CH_AMP;
      if (!cfg.encode_all && !reserved) begin
         run.text[0]  = b;
         run.last_idx = 3'd0;
      end else if (cfg.use_names && reserved) begin
         unique case (b)
            CH_LT: begin
               run.text[1] = "l"; run.text[2] = "t"; run.text[3] = CH_SEMI;
               run.last_idx = 3'd3;
            end
            CH_GT: begin
               run.text[1] = "g"; run.text[2] = "t"; run.text[3] = CH_SEMI;
               run.last_idx = 3'd3;
            end
            CH_AMP: begin
               run.text[1] = "a"; run.text[2] = "m"; run.text[3] = "p";
               run.text[4] = CH_SEMI;
               run.last_idx = 3'd4;
            end
            CH_APOS: begin
               run.text[1] = "a"; run.text[2] = "p"; run.text[3] = "o";
               run.text[4] = "s"; run.text[5] = CH_SEMI;
               run.last_idx = 3'd5;
            end
            default: begin
               run.text[1] = "q"; run.text[2] = "u"; run.text[3] = "o";
               run.text[4] = "t"; run.text[5] = CH_SEMI;
               run.last_idx = 3'd5;
            end
         endcase
      end else if (cfg.use_hex) begin
         run.text[1]  = CH_HASH;
         run.text[2]  = CH_X;
         run.text[3]  = hex_char(b[7:4]);
         run.text[4]  = hex_char(b[3:0]);
         run.text[5]  = CH_SEMI;
         run.last_idx = 3'd5;
      end else begin
         run.text[1] = CH_HASH;
         if (b >= 8'd100) begin
            run.text[idx] = CH_ZERO + {6'd0, hund};
            idx = idx + 3'd1;
         end
         if (b >= 8'd10) begin
            run.text[idx] = CH_ZERO + {4'd0, tens};
            idx = idx + 3'd1;
         end
         run.text[idx] = CH_ZERO + {4'd0, ones};
         idx = idx + 3'd1;
         run.text[idx] = CH_SEMI;
         run.last_idx  = idx;
      end
      return run;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/html_entity_encoder_unit.sv
// Each run is written to the queue and then loaded byte by byte into the output register.
// One output byte per cycle while rsp_stall is low; an input byte makes a run of 1 to 6
// bytes, set by its encoding, which the back end drains from the queue one byte per cycle.
// Input is taken every cycle the queue has room, so input and output overlap fully.
// Reset (synchronous, active high): use_hex = 1, use_names = 0, encode_all = 0; queue empty.
`default_nettype none
module html_entity_encoder_unit #(
   parameter int unsigned QUEUE_DEPTH = hee_pkg::QUEUE_DEPTH
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire hee_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output hee_pkg::rsp_type       rsp_data,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire [1:0]              csr_index,
   input  wire                    csr_wdata
);
   // Configuration registers. The port never pushes back; a write to an
   // index past the register list completes and changes nothing.
   hee_pkg::cfg_type cfg_ff, cfg_in;

   // Front-to-back queue signals.
   hee_pkg::run_type          q_wdata;
   hee_pkg::run_type          q_rdata;
   hee_pkg::queue_status_type q_status;
   logic                      q_push;
   logic                      q_pop;

   assign csr_ready = 1'b1;

   // Decode the register index; drop writes that hit no register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hee_pkg::CSR_USE_NAMES:  cfg_in.use_names  = csr_wdata;
            hee_pkg::CSR_USE_HEX:    cfg_in.use_hex    = csr_wdata;
            hee_pkg::CSR_ENCODE_ALL: cfg_in.encode_all = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.use_names  <= 1'b0;
         cfg_ff.use_hex    <= 1'b1;
         cfg_ff.encode_all <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: classify each accepted byte into a complete run combinationally
   // and write it to the queue. The sender is held only while the queue is full.
   hee_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_wdata   (q_wdata)
   );

   // Queue: decouples the combinational front end from the byte-serial back end.
   hee_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   // Back end: walk the head run byte by byte into the output register and
   // release the queue entry as its final byte is loaded.
   hee_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_rdata   (q_rdata),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // The queue can never report empty and full together.
   assert property (@(posedge clock) disable iff (reset)
      !(q_status.empty && q_status.full))
      else $error("queue reports empty and full at once");

   // An accepted transaction leaves the queue non-empty or a byte on the output.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (!q_status.empty || rsp_valid))
      else $error("accepted transaction vanished");

   // A message end flag only ever rides on the final byte of a run.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_message_end) |-> rsp_data.run_last)
      else $error("message end outside run end");
`endif

endmodule
`default_nettype wire

FILE: hdl/hee_front.sv
// Front end: accept input bytes and classify them into encoded runs.
`default_nettype none
module hee_front (
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire hee_pkg::req_type      req_data,
   input  wire hee_pkg::cfg_type      cfg,
   input  wire hee_pkg::queue_status_type q_status,
   output logic                       q_push,
   output hee_pkg::run_type           q_wdata
);
   // hold the sender while the queue has no room
   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;
   assign q_wdata   = hee_pkg::build_run(req_data, cfg);

endmodule
`default_nettype wire

FILE: hdl/hee_queue.sv
// Small first-in first-out queue of encoded runs between front and back.
`default_nettype none
module hee_queue #(
   parameter int unsigned DEPTH = hee_pkg::QUEUE_DEPTH
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   input  wire hee_pkg::run_type        wdata,
   input  wire                          pop,
   output hee_pkg::run_type             rdata,
   output hee_pkg::queue_status_type    status
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   hee_pkg::run_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CW'(DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rdata        = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/hee_back.sv
// Back end: serialize the head run, one byte per cycle while the output is not stalled, into the output register.
`default_nettype none
module hee_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire hee_pkg::run_type        q_rdata,
   input  wire hee_pkg::queue_status_type q_status,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output hee_pkg::rsp_type             rsp_data
);
   logic             rsp_valid_ff, rsp_valid_in;
   hee_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [2:0]       pos_ff, pos_in;
   logic             advance;
   logic             at_last;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign at_last = (pos_ff == q_rdata.last_idx);
   assign q_pop   = advance && !q_status.empty && at_last;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      pos_in       = pos_ff;
      if (advance) begin
         rsp_valid_in                = !q_status.empty;
         rsp_data_in.out_byte        = q_rdata.text[pos_ff];
         rsp_data_in.run_last        = at_last;
         rsp_data_in.out_message_end = at_last && q_rdata.msg_end;
         if (!q_status.empty) begin
            pos_in = at_last ? 3'd0 : pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pos_ff       <= 3'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: tb/sv/html_entity_encoder_checker.sv
// Output checker for the HTML entity encoder: predicts each encoded run and compares bytes.
`timescale 1ns / 1ps
module html_entity_encoder_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  hee_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  hee_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic             csr_wdata,
   input  logic             test_done,
   output int unsigned      fail_count,
   output int unsigned      pending_count,
   output int unsigned      items_seen,
   output int unsigned      results_seen
);
   import hee_pkg::*;

   cfg_type     enc_cfg;
   rsp_type     expected_bytes[$];
   rsp_type     want;
   logic        field_bad;
   logic        leftovers_reported = 1'b0;

   function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
      return (nib < 4'd10) ? 8'(CH_ZERO + nib) : 8'(CH_LOW_A + nib - 8'd10);
   endfunction

   // expand one input byte into its encoded run and queue every byte of it
   function automatic void predict_run(input req_type item);
      logic [7:0] text[$];
      logic [7:0] b;
      string      ent;
      rsp_type    r;
      b = item.data_byte;
      case (b)
         CH_LT:   ent = "lt";
         CH_GT:   ent = "gt";
         CH_AMP:  ent = "amp";
         CH_APOS: ent = "apos";
         CH_QUOT: ent = "quot";
         default: ent = "";
      endcase
      if (!enc_cfg.encode_all && ent.len() == 0) begin
         text.push_back(b);
      end else begin
         text.push_back(CH_AMP);
         if (enc_cfg.use_names && ent.len() != 0) begin
            for (int k = 0; k < ent.len(); k++) text.push_back(ent[k]);
         end else if (enc_cfg.use_hex) begin
            text.push_back(CH_HASH);
            text.push_back(CH_X);
            text.push_back(nibble_ascii(b[7:4]));
            text.push_back(nibble_ascii(b[3:0]));
         end else begin
            text.push_back(CH_HASH);
            if (b >= 8'd100) text.push_back(8'(CH_ZERO + b / 8'd100));
            if (b >= 8'd10)  text.push_back(8'(CH_ZERO + (b / 8'd10) % 8'd10));
            text.push_back(8'(CH_ZERO + b % 8'd10));
         end
         text.push_back(CH_SEMI);
      end
      foreach (text[k]) begin
         r.out_byte        = text[k];
         r.run_last        = (k == text.size() - 1);
         r.out_message_end = r.run_last & item.message_end;
         expected_bytes.push_back(r);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         enc_cfg = '{use_names: 1'b0, use_hex: 1'b1, encode_all: 1'b0};
         expected_bytes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_USE_NAMES:  enc_cfg.use_names  = csr_wdata;
               CSR_USE_HEX:    enc_cfg.use_hex    = csr_wdata;
               CSR_ENCODE_ALL: enc_cfg.encode_all = csr_wdata;
               default: ;
            endcase
         end
         // retire before predicting: a byte out always belongs to an earlier input
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected output byte, expected none actual %h/%b/%b", $time,
                        rsp_data.out_byte, rsp_data.run_last, rsp_data.out_message_end);
               fail_count++;
            end else begin
               want      = expected_bytes.pop_front();
               field_bad = 1'b0;
               if (rsp_data.out_byte !== want.out_byte) begin
                  $display("%0t: out_byte mismatch, expected %h actual %h", $time,
                           want.out_byte, rsp_data.out_byte);
                  field_bad = 1'b1;
               end
               if (rsp_data.run_last !== want.run_last) begin
                  $display("%0t: run_last mismatch, expected %b actual %b", $time,
                           want.run_last, rsp_data.run_last);
                  field_bad = 1'b1;
               end
               if (rsp_data.out_message_end !== want.out_message_end) begin
                  $display("%0t: out_message_end mismatch, expected %b actual %b", $time,
                           want.out_message_end, rsp_data.out_message_end);
                  field_bad = 1'b1;
               end
               if (field_bad) fail_count++;
            end
         end
         if (req_valid && !req_stall) begin
            items_seen++;
            predict_run(req_data);
         end
         if (test_done && !leftovers_reported) begin
            leftovers_reported = 1'b1;
            if (expected_bytes.size() != 0) begin
               $display("%0t: %0d output bytes never arrived, expected %h next, actual none",
                        $time, expected_bytes.size(), expected_bytes[0].out_byte);
               fail_count += expected_bytes.size();
            end
         end
      end
      pending_count = expected_bytes.size();
   end

endmodule

FILE: tb/sv/tb_html_entity_encoder_unit.sv
// Top-level testbench for the HTML entity encoder: stimulus, output flow control and verdict.
`timescale 1ns / 1ps
module tb_html_entity_encoder_unit;
   import hee_pkg::*;

   // index 3 is not a register; writes to it must leave the configuration alone
   localparam logic [1:0]  CSR_UNUSED     = 2'd3;
   localparam int unsigned NUM_PHASES     = 12;
   localparam int unsigned PHASE_ITEMS    = 28;
   localparam int unsigned HOLDOFF_CYCLES = 80;
   localparam int unsigned DRAIN_CYCLES   = 12;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam logic [7:0]  BOUNDARY_BYTES [8] = '{8'd0, 8'd9, 8'd10, 8'd99,
                                                  8'd100, 8'd199, 8'd200, 8'd255};

   typedef enum logic [1:0] {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_ALTERNATE} flow_mode_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic        csr_wdata = 1'b0;
   logic        test_done = 1'b0;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned items_seen;
   int unsigned results_seen;
   int unsigned csr_writes    = 0;
   int unsigned idle_cycles   = 0;
   logic [7:0]  settings_seen = '0;

   // output-side flow control state
   logic          holdoff_req = 1'b0;
   logic          holdoff_ack = 1'b0;
   int unsigned   hold_left   = 0;
   int unsigned   flow_left   = 0;
   flow_mode_type flow_mode   = FLOW_FREE;

   always #1 clock = ~clock;

   html_entity_encoder_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   html_entity_encoder_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .test_done     (test_done),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .items_seen    (items_seen),
      .results_seen  (results_seen)
   );

   // Output flow control. A requested hold-off wins over everything: keep the
   // output stalled until the hold-off count runs out, so the encoder queue fills and
   // pushes back on the input. Otherwise switch at random intervals between free flow,
   // light and heavy random stalls and a strict alternating pattern.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (holdoff_req != holdoff_ack) begin
         holdoff_ack <= holdoff_req;
         hold_left   <= HOLDOFF_CYCLES;
         rsp_stall   <= 1'b1;
      end else begin
         if (flow_left == 0) begin
            flow_mode <= flow_mode_type'($urandom_range(0, 3));
            flow_left <= $urandom_range(20, 150);
         end else begin
            flow_left <= flow_left - 1;
         end
         case (flow_mode)
            FLOW_FREE:      rsp_stall <= 1'b0;
            FLOW_LIGHT:     rsp_stall <= ($urandom_range(0, 3) == 0);
            FLOW_HEAVY:     rsp_stall <= ($urandom_range(0, 9) < 7);
            FLOW_ALTERNATE: rsp_stall <= ~rsp_stall;
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   // Watchdog: count cycles with no transaction on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d output bytes outstanding",
                  $time, idle_cycles, pending_count);
         $display("html_entity_encoder_unit test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one input byte and hold it until taken. Enter and leave at a falling
   // edge; valid stays high so a following call can chain without a bubble.
   task automatic send_item(input logic [7:0] data_byte, input logic last_in_msg);
      req_data  <= '{data_byte: data_byte, message_end: last_in_msg};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic req_idle();
      req_valid <= 1'b0;
   endtask

   // Wait until every predicted output byte has come out.
   task automatic wait_drained();
      do @(negedge clock); while (pending_count != 0);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_writes++;
   endtask

   // Drain the encoder, then program all three registers. Each time also poke
   // the unused index, which must have no effect.
   task automatic apply_setting(input logic names, input logic hex, input logic all_bytes);
      wait_drained();
      csr_write(CSR_UNUSED, 1'($urandom_range(0, 1)));
      csr_write(CSR_USE_NAMES, names);
      csr_write(CSR_USE_HEX, hex);
      csr_write(CSR_ENCODE_ALL, all_bytes);
      csr_valid <= 1'b0;
      settings_seen[{names, hex, all_bytes}] = 1'b1;
   endtask

   initial begin
      logic [7:0]  directed_bytes[$];
      logic [7:0]  b;
      logic [2:0]  mode_bits;
      int unsigned sent;
      int unsigned burst;
      int unsigned gap;
      logic        quiet;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset values, so reserved bytes come out as hex references;
      // plain bytes, both byte extremes and every reserved character.
      apply_setting(1'b0, 1'b1, 1'b0);
      directed_bytes = '{8'h00, 8'hFF, 8'h61, CH_LT, CH_GT, CH_AMP, CH_APOS, CH_QUOT};
      foreach (directed_bytes[k]) send_item(directed_bytes[k], k == 1 || k == 7);
      req_idle();

      // Directed: named entities for all five reserved characters, then a plain byte.
      apply_setting(1'b1, 1'b1, 1'b0);
      directed_bytes = '{CH_LT, CH_GT, CH_AMP, CH_APOS, CH_QUOT, 8'h41};
      foreach (directed_bytes[k]) send_item(directed_bytes[k], k == 5);
      req_idle();

      // Directed: decimal form on every byte, across each digit-count boundary
      // and into the upper half, which must read unsigned.
      apply_setting(1'b0, 1'b0, 1'b1);
      directed_bytes = '{8'd0, 8'd9, 8'd10, 8'd99, 8'd100, 8'd199, 8'd200, 8'd255, 8'd128};
      foreach (directed_bytes[k]) send_item(directed_bytes[k], k == 8);
      req_idle();

      // Random phases. The first eight step through every register setting,
      // the rest pick settings at random. Phase 5 holds the output off while
      // the input keeps coming; phase 3 pauses halfway until the output drains.
      for (int unsigned p = 0; p < NUM_PHASES; p++) begin
         mode_bits = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
         apply_setting(mode_bits[2], mode_bits[1], mode_bits[0]);
         quiet = (p % 4 == 1);
         if (p == 5) holdoff_req <= ~holdoff_req;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(1, 16);
            if (burst > PHASE_ITEMS - sent) burst = PHASE_ITEMS - sent;
            repeat (burst) begin
               // bias toward reserved characters and digit-count boundaries
               case ($urandom_range(0, 9))
                  0, 1, 2: begin
                     case ($urandom_range(0, 4))
                        0:       b = CH_LT;
                        1:       b = CH_GT;
                        2:       b = CH_AMP;
                        3:       b = CH_APOS;
                        default: b = CH_QUOT;
                     endcase
                  end
                  3:       b = BOUNDARY_BYTES[$urandom_range(0, 7)];
                  default: b = 8'($urandom_range(0, 255));
               endcase
               send_item(b, $urandom_range(0, 7) == 0);
               sent++;
               if (p == 3 && sent == PHASE_ITEMS / 2) begin
                  req_idle();
                  wait_drained();
               end
            end
            // drop valid for a random gap between bursts, except in quiet phases
            gap = quiet ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
               req_idle();
               repeat (gap) @(negedge clock);
            end
         end
         req_idle();
      end

      // Let the last runs drain, then give stray bytes time to show up.
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      test_done <= 1'b1;
      repeat (2) @(negedge clock);

      $display("Run covered %0d input bytes, %0d output bytes, %0d register writes,",
               items_seen, results_seen, csr_writes);
      $display("%0d of 8 register settings, one long output hold-off and mid-stream drains.",
               $countones(settings_seen));
      if (fail_count == 0) begin
         $display("html_entity_encoder_unit test passed");
      end else begin
         $display("html_entity_encoder_unit test failed");
      end
      $finish;
   end

endmodule

FILE: html_entity_encoder_unit.f
hdl/hee_pkg.sv
hdl/hee_front.sv
hdl/hee_queue.sv
hdl/hee_back.sv
hdl/html_entity_encoder_unit.sv
tb/sv/html_entity_encoder_checker.sv
tb/sv/tb_html_entity_encoder_unit.sv
